// ===== hw/rtl/dro_pkg.sv =====
// Shared types and constants for the DRO version 1 command stream decoder.
// Holds the transfer structs, result kinds, opcodes and the header magic.
// No dependencies.
package dro_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int HDR_BYTES  = 24;
    localparam int APB_ADDR_W = 3;
    localparam int RATE_W     = 18;
    localparam int MS_W       = 17;
    localparam int FRAMES_W   = 24;

    localparam logic [0:0] REG_SAMPLE_RATE  = 1'b0;
    localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_DELAY  = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    localparam logic [7:0] OP_DELAY8   = 8'h00;
    localparam logic [7:0] OP_DELAY16  = 8'h01;
    localparam logic [7:0] OP_BANK_LO  = 8'h02;
    localparam logic [7:0] OP_BANK_HI  = 8'h03;
    localparam logic [7:0] OP_ESCAPE   = 8'h04;

    localparam logic [7:0] MAGIC_BYTES [8] = '{
        8'h44, 8'h42, 8'h52, 8'h41, 8'h57, 8'h4F, 8'h50, 8'h4C
    };

    // Frames are floor(ms * rate / 1000), computed as floor((p >> 3) / 125).
    localparam logic [34:0] SAT_PRODUCT  = 35'd16777216000;
    localparam logic [31:0] RECIP_125    = 32'd2199023256;
    localparam int          RECIP_SHIFT  = 38;
    localparam logic [FRAMES_W-1:0] MAX_FRAMES = 24'hFFFFFF;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       file_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          kind;
        logic [8:0]          reg_address;
        logic [7:0]          reg_value;
        logic [FRAMES_W-1:0] delay_frames;
        logic                run_last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]      kind;
        logic [8:0]      reg_address;
        logic [7:0]      reg_value;
        logic [MS_W-1:0] delay_ms;
        logic            end_after;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic [8:0] reg_address;
        logic [7:0] reg_value;
        logic       end_after;
    } t_cmd_info;

endpackage

// ===== hw/rtl/dro_front.sv =====
// Front end of the decoder: header check and command classification.
// Turns each accepted byte into at most one command entry for the queue.
// Depends on dro_pkg.
module dro_front
    import dro_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_wr,
    output t_cmd     o_cmd
);

    localparam logic [3:0] PH_HEADER     = 4'd0;
    localparam logic [3:0] PH_OPCODE     = 4'd1;
    localparam logic [3:0] PH_DELAY8     = 4'd2;
    localparam logic [3:0] PH_DELAY16_LO = 4'd3;
    localparam logic [3:0] PH_DELAY16_HI = 4'd4;
    localparam logic [3:0] PH_ESC_REG    = 4'd5;
    localparam logic [3:0] PH_ESC_VAL    = 4'd6;
    localparam logic [3:0] PH_WRITE_VAL  = 4'd7;
    localparam logic [3:0] PH_DRAIN      = 4'd8;

    localparam logic [4:0] HDR_LAST = 5'(HDR_BYTES - 1);

    logic [3:0]  r_phase, n_phase;
    logic [4:0]  r_hdr_idx, n_hdr_idx;
    logic        r_hdr_good, n_hdr_good;
    logic [31:0] r_len, n_len;
    logic [31:0] r_count, n_count;
    logic        r_bank, n_bank;
    logic [7:0]  r_held, n_held;

    logic [7:0] b;
    logic       last;

    assign b    = i_item.file_byte;
    assign last = i_item.file_end;

    always_comb begin
        n_phase    = r_phase;
        n_hdr_idx  = r_hdr_idx;
        n_hdr_good = r_hdr_good;
        n_len      = r_len;
        n_count    = r_count;
        n_bank     = r_bank;
        n_held     = r_held;
        o_wr       = 1'b0;
        o_cmd      = '0;
        if (i_accept) begin
            if (r_phase == PH_HEADER) begin
                if (r_hdr_idx < 5'd8) begin
                    if (b != MAGIC_BYTES[r_hdr_idx[2:0]]) begin
                        n_hdr_good = 1'b0;
                    end
                end else if (r_hdr_idx == 5'd8 || r_hdr_idx == 5'd9) begin
                    if (b != 8'd0) begin
                        n_hdr_good = 1'b0;
                    end
                end else if (r_hdr_idx == 5'd16) begin
                    n_len[7:0] = r_len[7:0] | b;
                end else if (r_hdr_idx == 5'd17) begin
                    n_len[15:8] = r_len[15:8] | b;
                end else if (r_hdr_idx == 5'd18) begin
                    n_len[23:16] = r_len[23:16] | b;
                end else if (r_hdr_idx == 5'd19) begin
                    n_len[31:24] = r_len[31:24] | b;
                end
                n_hdr_idx = r_hdr_idx + 5'd1;
                if (r_hdr_idx >= HDR_LAST) begin
                    if (n_hdr_good) begin
                        n_phase = PH_OPCODE;
                        if (last) begin
                            o_wr       = 1'b1;
                            o_cmd.kind = KIND_END;
                        end
                    end else begin
                        o_wr       = 1'b1;
                        o_cmd.kind = KIND_REJECT;
                        n_phase    = PH_DRAIN;
                    end
                end else if (last) begin
                    o_wr       = 1'b1;
                    o_cmd.kind = KIND_REJECT;
                end
            end else if (r_phase != PH_DRAIN) begin
                n_count = r_count + 32'd1;
                unique case (r_phase)
                    PH_OPCODE: begin
                        if (b == OP_DELAY8) begin
                            n_phase = PH_DELAY8;
                        end else if (b == OP_DELAY16) begin
                            n_phase = PH_DELAY16_LO;
                        end else if (b == OP_BANK_LO) begin
                            n_bank = 1'b0;
                        end else if (b == OP_BANK_HI) begin
                            n_bank = 1'b1;
                        end else if (b == OP_ESCAPE) begin
                            n_phase = PH_ESC_REG;
                        end else begin
                            n_held  = b;
                            n_phase = PH_WRITE_VAL;
                        end
                    end
                    PH_DELAY8: begin
                        o_wr           = 1'b1;
                        o_cmd.kind     = KIND_DELAY;
                        o_cmd.delay_ms = {9'd0, b} + 17'd1;
                        n_phase        = PH_OPCODE;
                    end
                    PH_DELAY16_LO: begin
                        n_held  = b;
                        n_phase = PH_DELAY16_HI;
                    end
                    PH_DELAY16_HI: begin
                        o_wr           = 1'b1;
                        o_cmd.kind     = KIND_DELAY;
                        o_cmd.delay_ms = {1'b0, b, r_held} + 17'd1;
                        n_phase        = PH_OPCODE;
                    end
                    PH_ESC_REG: begin
                        n_held  = b;
                        n_phase = PH_ESC_VAL;
                    end
                    PH_ESC_VAL, PH_WRITE_VAL: begin
                        o_wr              = 1'b1;
                        o_cmd.kind        = KIND_WRITE;
                        o_cmd.reg_address = {r_bank, r_held};
                        o_cmd.reg_value   = b;
                        n_phase           = PH_OPCODE;
                    end
                    default: begin
                        n_phase = PH_DRAIN;
                    end
                endcase
                if (last || (r_len != 32'd0 && n_count == r_len)) begin
                    if (o_wr) begin
                        o_cmd.end_after = 1'b1;
                    end else begin
                        o_wr       = 1'b1;
                        o_cmd.kind = KIND_END;
                    end
                    n_phase = PH_DRAIN;
                end
            end
            if (last) begin
                n_phase    = PH_HEADER;
                n_hdr_idx  = 5'd0;
                n_hdr_good = 1'b1;
                n_len      = 32'd0;
                n_count    = 32'd0;
                n_bank     = 1'b0;
                n_held     = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_idx  <= 5'd0;
            r_hdr_good <= 1'b1;
            r_len      <= 32'd0;
            r_count    <= 32'd0;
            r_bank     <= 1'b0;
            r_held     <= 8'd0;
        end else begin
            r_phase    <= n_phase;
            r_hdr_idx  <= n_hdr_idx;
            r_hdr_good <= n_hdr_good;
            r_len      <= n_len;
            r_count    <= n_count;
            r_bank     <= n_bank;
            r_held     <= n_held;
        end
    end

endmodule

// ===== hw/rtl/dro_queue.sv =====
// Short command queue between the front end and the back end.
// Register-based FIFO, one write per cycle while not full and one read while not empty.
// Depends on dro_pkg.
module dro_queue
    import dro_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wr_data,
    output logic o_full,
    input  logic i_rd,
    output t_cmd o_rd_data,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_wr, do_rd;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== hw/rtl/dro_back.sv =====
// Back end of the decoder: delay conversion pipeline and result register.
// Converts milliseconds to frames and splits a command from a trailing end result.
// Depends on dro_pkg.
module dro_back
    import dro_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [RATE_W-1:0] i_rate,
    input  logic              i_q_empty,
    input  t_cmd              i_q_data,
    output logic              o_q_rd,
    output logic              o_empty,
    input  logic              i_pop,
    output t_out_item         o_result
);

    logic        r_s1_v, r_s2_v, r_s3_v;
    t_cmd_info   r_s1_info, r_s2_info, r_s3_info;
    logic [34:0] r_s1_prod;
    logic        r_s2_sat;
    logic [30:0] r_s2_quot8;
    logic [FRAMES_W-1:0] r_s3_frames;
    logic        r_split, n_split;
    logic        r_out_v, n_out_v;
    t_out_item   r_out, n_out;

    logic        out_free;
    logic        s3_done;
    logic        en;
    logic [62:0] recip_prod;
    t_cmd_info   q_info;

    assign q_info = '{kind: i_q_data.kind, reg_address: i_q_data.reg_address,
                      reg_value: i_q_data.reg_value, end_after: i_q_data.end_after};

    assign out_free   = !r_out_v || i_pop;
    assign recip_prod = 63'(r_s2_quot8) * 63'(RECIP_125);

    always_comb begin
        n_split = r_split;
        n_out_v = r_out_v && !i_pop;
        n_out   = r_out;
        s3_done = 1'b0;
        if (r_s3_v && out_free) begin
            n_out_v = 1'b1;
            if (r_s3_info.end_after && !r_split) begin
                n_out   = '{kind: r_s3_info.kind, reg_address: r_s3_info.reg_address,
                            reg_value: r_s3_info.reg_value, delay_frames: r_s3_frames,
                            run_last: 1'b0};
                n_split = 1'b1;
            end else if (r_s3_info.end_after) begin
                n_out   = '{kind: KIND_END, reg_address: 9'd0, reg_value: 8'd0,
                            delay_frames: '0, run_last: 1'b1};
                n_split = 1'b0;
                s3_done = 1'b1;
            end else begin
                n_out   = '{kind: r_s3_info.kind, reg_address: r_s3_info.reg_address,
                            reg_value: r_s3_info.reg_value, delay_frames: r_s3_frames,
                            run_last: 1'b1};
                s3_done = 1'b1;
            end
        end
    end

    assign en     = !r_s3_v || s3_done;
    assign o_q_rd = en && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_info   <= q_info;
            r_s1_prod   <= 35'(i_q_data.delay_ms) * 35'(i_rate);
            r_s2_info   <= r_s1_info;
            r_s2_sat    <= (r_s1_prod >= SAT_PRODUCT);
            r_s2_quot8  <= r_s1_prod[33:3];
            r_s3_info   <= r_s2_info;
            r_s3_frames <= r_s2_sat ? MAX_FRAMES :
                           recip_prod[RECIP_SHIFT + FRAMES_W - 1:RECIP_SHIFT];
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_split <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (en) begin
                r_s1_v <= !i_q_empty;
                r_s2_v <= r_s1_v;
                r_s3_v <= r_s2_v;
            end
            r_split <= n_split;
            r_out_v <= n_out_v;
        end
    end

    assign o_empty  = !r_out_v;
    assign o_result = r_out;

endmodule

// ===== hw/rtl/dro_v1_command_stream_decoder_top.sv =====
// Top level of the DRO version 1 command stream decoder.
// Throughput: one byte per cycle while not full; a byte with two results needs two pops.
// Path: a byte's first result goes through the command queue, the three-stage
// multiply-by-reciprocal delay conversion and the result register to the result ports.
// Reset: synchronous, active low; clears parse state, queue and pipeline, sample rate 44100.
// Depends on dro_pkg, dro_front, dro_queue and dro_back.
module dro_v1_command_stream_decoder_top
    import dro_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [RATE_W-1:0] r_rate;
    logic              accept;
    logic              cmd_wr;
    t_cmd              cmd_wr_data;
    logic              q_rd;
    logic              q_empty;
    t_cmd              q_rd_data;
    logic              reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_SAMPLE_RATE);
    assign prdata  = reg_hit ? {{(32 - RATE_W){1'b0}}, r_rate} : 32'd0;
    assign accept  = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_rate <= pwdata[RATE_W-1:0];
        end
    end

    dro_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_item),
        .o_wr    (cmd_wr),
        .o_cmd   (cmd_wr_data)
    );

    dro_queue #(
        .DEPTH(QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (cmd_wr),
        .i_wr_data(cmd_wr_data),
        .o_full   (full),
        .i_rd     (q_rd),
        .o_rd_data(q_rd_data),
        .o_empty  (q_empty)
    );

    dro_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rate   (r_rate),
        .i_q_empty(q_empty),
        .i_q_data (q_rd_data),
        .o_q_rd   (q_rd),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

endmodule

// ===== tb/dro_v1_command_stream_decoder_checker.sv =====
// Checker for the DRO version 1 command stream decoder: predicts the results of every
// accepted file byte, tracks sample rate writes, and compares each result transfer.
// Depends on dro_pkg.
`timescale 1ns / 1ps

module dro_v1_command_stream_decoder_checker
    import dro_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_full,
    input  t_in_item              i_item,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  t_out_item             i_result,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [31:0]           i_pwdata,
    input  logic                  i_pready,
    output int                    o_mismatches,
    output int                    o_waiting
);

    localparam logic [APB_ADDR_W-1:0] RATE_ADDR = {REG_SAMPLE_RATE, 2'b00};

    typedef enum logic [3:0] {
        ST_HEADER,
        ST_OPCODE,
        ST_DELAY8,
        ST_DELAY16_LO,
        ST_DELAY16_HI,
        ST_ESC_REG,
        ST_ESC_VAL,
        ST_WRITE_VAL,
        ST_DRAIN
    } t_parse_state;

    logic [RATE_W-1:0] rate;
    t_parse_state      parse_state;
    int                hdr_index;
    logic              hdr_good;
    logic [31:0]       stream_len;
    logic [31:0]       stream_taken;
    logic              bank_high;
    logic [7:0]        held;

    t_out_item         pending_results[$];
    int                mismatches = 0;
    int                waiting = 0;
    int                results_seen = 0;

    assign o_mismatches = mismatches;
    assign o_waiting    = waiting;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 100) begin
            $display("[%0t] result %0d: %s is 0x%0h, predicted 0x%0h",
                     $time, results_seen, what, got, want);
        end
        mismatches++;
    endtask

    task automatic clear_parse();
        parse_state  = ST_HEADER;
        hdr_index    = 0;
        hdr_good     = 1'b1;
        stream_len   = '0;
        stream_taken = '0;
        bank_high    = 1'b0;
        held         = '0;
    endtask

    function automatic logic [FRAMES_W-1:0] frames_for(input logic [MS_W-1:0] ms);
        logic [63:0] product;
        product = (64'(ms) * 64'(rate)) / 64'd1000;
        if (product > 64'(MAX_FRAMES)) return MAX_FRAMES;
        return product[FRAMES_W-1:0];
    endfunction

    function automatic t_out_item make_result(input logic [1:0] kind,
                                              input logic [8:0] addr,
                                              input logic [7:0] value,
                                              input logic [FRAMES_W-1:0] frames);
        t_out_item r;
        r.kind         = kind;
        r.reg_address  = addr;
        r.reg_value    = value;
        r.delay_frames = frames;
        r.run_last     = 1'b0;
        return r;
    endfunction

    task automatic decode_byte(input t_in_item it);
        t_out_item  made[$];
        logic [7:0] b;
        logic       last;
        int         k;
        b    = it.file_byte;
        last = it.file_end;
        if (parse_state == ST_HEADER) begin
            if (hdr_index < 8) begin
                if (b != MAGIC_BYTES[hdr_index]) hdr_good = 1'b0;
            end else if (hdr_index == 8 || hdr_index == 9) begin
                if (b != 8'h00) hdr_good = 1'b0;
            end else if (hdr_index >= 16 && hdr_index <= 19) begin
                stream_len = stream_len | (32'(b) << (8 * (hdr_index - 16)));
            end
            hdr_index++;
            if (hdr_index >= HDR_BYTES) begin
                if (hdr_good) begin
                    parse_state = ST_OPCODE;
                    if (last) made.push_back(make_result(KIND_END, '0, '0, '0));
                end else begin
                    made.push_back(make_result(KIND_REJECT, '0, '0, '0));
                    parse_state = ST_DRAIN;
                end
            end else if (last) begin
                made.push_back(make_result(KIND_REJECT, '0, '0, '0));
            end
        end else if (parse_state != ST_DRAIN) begin
            stream_taken++;
            case (parse_state)
                ST_OPCODE: begin
                    if (b == OP_DELAY8) parse_state = ST_DELAY8;
                    else if (b == OP_DELAY16) parse_state = ST_DELAY16_LO;
                    else if (b == OP_BANK_LO) bank_high = 1'b0;
                    else if (b == OP_BANK_HI) bank_high = 1'b1;
                    else if (b == OP_ESCAPE) parse_state = ST_ESC_REG;
                    else begin
                        held        = b;
                        parse_state = ST_WRITE_VAL;
                    end
                end
                ST_DELAY8: begin
                    made.push_back(make_result(KIND_DELAY, '0, '0,
                                               frames_for(MS_W'(b) + 1'b1)));
                    parse_state = ST_OPCODE;
                end
                ST_DELAY16_LO: begin
                    held        = b;
                    parse_state = ST_DELAY16_HI;
                end
                ST_DELAY16_HI: begin
                    made.push_back(make_result(KIND_DELAY, '0, '0,
                                               frames_for(MS_W'({b, held}) + 1'b1)));
                    parse_state = ST_OPCODE;
                end
                ST_ESC_REG: begin
                    held        = b;
                    parse_state = ST_ESC_VAL;
                end
                ST_ESC_VAL, ST_WRITE_VAL: begin
                    made.push_back(make_result(KIND_WRITE, {bank_high, held}, b, '0));
                    parse_state = ST_OPCODE;
                end
                default: parse_state = ST_DRAIN;
            endcase
            if (last || (stream_len != 0 && stream_taken == stream_len)) begin
                made.push_back(make_result(KIND_END, '0, '0, '0));
                parse_state = ST_DRAIN;
            end
        end
        if (made.size() > 0) made[made.size() - 1].run_last = 1'b1;
        for (k = 0; k < made.size(); k++) pending_results.push_back(made[k]);
        if (last) clear_parse();
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            rate = RATE_RESET;
            clear_parse();
            pending_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == RATE_ADDR) begin
                rate = i_pwdata[RATE_W-1:0];
            end
            if (i_pop && !i_empty) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unpredicted result, kind", 32'(i_result.kind), '0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_result.kind != want.kind)
                        report_mismatch("kind", 32'(i_result.kind), 32'(want.kind));
                    if (i_result.reg_address != want.reg_address)
                        report_mismatch("reg_address", 32'(i_result.reg_address),
                                        32'(want.reg_address));
                    if (i_result.reg_value != want.reg_value)
                        report_mismatch("reg_value", 32'(i_result.reg_value),
                                        32'(want.reg_value));
                    if (i_result.delay_frames != want.delay_frames)
                        report_mismatch("delay_frames", 32'(i_result.delay_frames),
                                        32'(want.delay_frames));
                    if (i_result.run_last != want.run_last)
                        report_mismatch("run_last", 32'(i_result.run_last),
                                        32'(want.run_last));
                end
            end
            if (i_push && !i_full) decode_byte(i_item);
        end
        waiting = pending_results.size();
    end

endmodule

// ===== tb/tb_dro_v1_command_stream_decoder_top.sv =====
// Testbench top for the DRO version 1 command stream decoder: drives files byte by
// byte, sample rate writes and result pops, and gives the verdict.
// Depends on dro_pkg, dro_v1_command_stream_decoder_top and the checker module.
`timescale 1ns / 1ps

module tb_dro_v1_command_stream_decoder_top
    import dro_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [APB_ADDR_W-1:0] RATE_ADDR = {REG_SAMPLE_RATE, 2'b00};

    localparam int HDR_CLEAN       = 0;
    localparam int HDR_BAD_MAGIC   = 1;
    localparam int HDR_BAD_VERSION = 2;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    t_in_item              i_item;
    logic                  empty;
    logic                  pop;
    t_out_item             o_result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int                    mismatches;
    int                    waiting;
    int                    n_sent = 0;
    int                    cycles = 0;
    logic [7:0]            file_bytes[$];

    always #4 i_clk = ~i_clk;

    dro_v1_command_stream_decoder_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    dro_v1_command_stream_decoder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (i_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (o_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_mismatches (mismatches),
        .o_waiting    (waiting)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] data_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25) return 8'hFF;
        if (pick < 35) return 8'h00;
        return 8'($urandom());
    endfunction

    function automatic bit no_idling();
        return n_sent >= 320 && n_sent < 420;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!no_idling() && $urandom_range(99) < 26) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= {b, last};
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        n_sent++;
    endtask

    task automatic send_file();
        int k;
        for (k = 0; k < file_bytes.size(); k++) begin
            send_byte(file_bytes[k], k == file_bytes.size() - 1);
        end
        file_bytes.delete();
    endtask

    task automatic add_header(input int damage, input logic [31:0] length);
        int k;
        for (k = 0; k < HDR_BYTES; k++) begin
            if (k < 8) file_bytes.push_back(MAGIC_BYTES[k]);
            else if (k == 8 || k == 9) file_bytes.push_back(8'h00);
            else if (k >= 16 && k <= 19) file_bytes.push_back(length[8*(k-16) +: 8]);
            else file_bytes.push_back(8'($urandom()));
        end
        if (damage == HDR_BAD_MAGIC) begin
            k = $urandom_range(7);
            file_bytes[k] = file_bytes[k] ^ 8'($urandom_range(255, 1));
        end else if (damage == HDR_BAD_VERSION) begin
            file_bytes[8 + $urandom_range(1)] = 8'($urandom_range(255, 1));
        end
    endtask

    // Result side: random stalls, one long hold-off that fills the block, and a
    // stretch without stalls.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_sent >= 200) begin
                hold_done = 1'b1;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (no_idling()) begin
                pop <= 1'b1;
            end else begin
                pop <= ($urandom_range(99) >= 26);
            end
        end
    end

    initial begin
        int unsigned rate_plan[6];
        int          ph;
        int          phase_bytes;
        int          shape;
        int          pick;
        int          n_cmd_bytes;
        int          k;
        logic [31:0] len;

        push    = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // File that ends inside the header.
        for (k = 0; k < 3; k++) file_bytes.push_back(MAGIC_BYTES[k]);
        send_file();

        // Good header and nothing after it.
        add_header(HDR_CLEAN, 32'd0);
        send_file();

        // Every command with extreme operands; the last write shares its byte with the end.
        add_header(HDR_CLEAN, 32'd0);
        file_bytes.push_back(OP_DELAY8);  file_bytes.push_back(8'h00);
        file_bytes.push_back(OP_DELAY8);  file_bytes.push_back(8'hFF);
        file_bytes.push_back(OP_DELAY16); file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(OP_BANK_HI);
        file_bytes.push_back(OP_ESCAPE);  file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(OP_ESCAPE);  file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h7F);
        file_bytes.push_back(OP_BANK_LO);
        file_bytes.push_back(8'h05);      file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);      file_bytes.push_back(8'hFF);
        send_file();

        // Header length cuts an escaped write in half; the rest of the file is ignored.
        add_header(HDR_CLEAN, 32'd4);
        file_bytes.push_back(OP_DELAY8);  file_bytes.push_back(8'h05);
        file_bytes.push_back(OP_ESCAPE);  file_bytes.push_back(8'h10);
        file_bytes.push_back(8'h22);      file_bytes.push_back(8'h33);
        send_file();

        rate_plan[0] = 1;
        rate_plan[1] = 192000;
        rate_plan[2] = 0;
        rate_plan[3] = 262143;
        rate_plan[4] = $urandom_range(192000, 1);
        rate_plan[5] = 44100;

        for (ph = 0; ph < 6; ph++) begin
            push <= 1'b0;
            while (waiting != 0) @(negedge i_clk);
            repeat (8) @(negedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= RATE_ADDR;
            pwdata  <= {14'($urandom()), rate_plan[ph][RATE_W-1:0]};
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;

            phase_bytes = 0;
            while (phase_bytes < 60) begin
                shape = $urandom_range(99);
                if (shape < 70) begin
                    add_header(HDR_CLEAN, 32'd0);
                    repeat ($urandom_range(12)) begin
                        case ($urandom_range(5))
                            0: begin
                                file_bytes.push_back(OP_DELAY8);
                                file_bytes.push_back(data_byte());
                            end
                            1: begin
                                file_bytes.push_back(OP_DELAY16);
                                file_bytes.push_back(data_byte());
                                file_bytes.push_back(data_byte());
                            end
                            2: file_bytes.push_back(OP_BANK_LO);
                            3: file_bytes.push_back(OP_BANK_HI);
                            4: begin
                                file_bytes.push_back(OP_ESCAPE);
                                file_bytes.push_back(data_byte());
                                file_bytes.push_back(data_byte());
                            end
                            default: begin
                                file_bytes.push_back(8'($urandom_range(255, 5)));
                                file_bytes.push_back(data_byte());
                            end
                        endcase
                    end
                    n_cmd_bytes = file_bytes.size() - HDR_BYTES;
                    pick = $urandom_range(9);
                    if (pick < 5) len = 32'd0;
                    else if (pick < 7) len = n_cmd_bytes;
                    else if (pick < 9) len = $urandom_range(n_cmd_bytes, 1);
                    else if ($urandom_range(1) == 1) len = $urandom();
                    else len = n_cmd_bytes + $urandom_range(300, 1);
                    for (k = 0; k < 4; k++) file_bytes[16 + k] = len[8*k +: 8];
                end else if (shape < 80) begin
                    add_header(HDR_BAD_MAGIC, $urandom());
                    repeat ($urandom_range(3)) file_bytes.push_back(8'($urandom()));
                end else if (shape < 88) begin
                    add_header(HDR_BAD_VERSION, $urandom());
                    repeat ($urandom_range(3)) file_bytes.push_back(8'($urandom()));
                end else begin
                    add_header(HDR_CLEAN, $urandom());
                    pick = $urandom_range(HDR_BYTES - 1, 1);
                    while (file_bytes.size() > pick) file_bytes.delete(file_bytes.size() - 1);
                end
                phase_bytes += file_bytes.size();
                send_file();
            end
        end

        push <= 1'b0;
        while (waiting != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
